>>> rtl/rigid_body_2d_step_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rigid body step block
// Concurrent checks that compile out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RIGID_BODY_2D_STEP_DEFINES_SVH
`define RIGID_BODY_2D_STEP_DEFINES_SVH
`ifndef SYNTHESIS
`define RB2S_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");
`define RB2S_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define RB2S_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RB2S_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/rb2s_pkg.sv
// ----------------------------------------------------------------------------
// rb2s_pkg
// Shared types, codes and saturation helpers of the rigid body step block.
// ----------------------------------------------------------------------------
`default_nettype none
package rb2s_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 31;

  localparam logic [CfgIdxW-1:0] CFG_MASS      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FRICTION  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FRIC_SCL  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_LIM = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_FALL_LIM  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_GRAVITY   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_GRAV_EN   = 3'd6;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_MUL_FX,
    OP_MUL_FY,
    OP_DIV_ACC,
    OP_ADD_AX,
    OP_ADD_AY,
    OP_MUL_C1,
    OP_MUL_C2,
    OP_MUL_C3,
    OP_SQ_X,
    OP_SQ_Y,
    OP_SQRT,
    OP_ZERO_V,
    OP_MUL_VXC,
    OP_MUL_VYC,
    OP_DIV_LEN,
    OP_SUB_X,
    OP_SUB_Y,
    OP_MUL_G,
    OP_ADD_G,
    OP_CLAMP,
    OP_MUL_VXL,
    OP_MUL_VYL,
    OP_SET_X,
    OP_SET_Y,
    OP_MUL_PX,
    OP_MUL_PY,
    OP_ADD_PX,
    OP_ADD_PY,
    OP_LOAD
  } op_e;

  typedef struct packed {
    logic capture;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic sqrt_busy;
    logic len_le_c;
    logic len_gt_lim;
    logic grav;
    logic ground;
  } sts_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [31:0] sat_vel(input logic signed [65:0] x);
    if (x[65:31] == '0 || x[65:31] == '1) begin
      sat_vel = x[31:0];
    end else begin
      sat_vel = x[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  endfunction

  function automatic logic signed [47:0] sat_pos(input logic signed [49:0] x);
    if (x[49:47] == '0 || x[49:47] == '1) begin
      sat_pos = x[47:0];
    end else begin
      sat_pos = x[49] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
    end
  endfunction

endpackage
`default_nettype wire

>>> rtl/rb2s_div.sv
// ----------------------------------------------------------------------------
// rb2s_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rb2s_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] num_i,
  input  wire logic [31:0] den_i,
  output logic             busy_o,
  output logic [63:0]      quo_o
);

  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [63:0] num_q;
  logic [31:0] rem_q;
  logic [31:0] den_q;
  logic [32:0] sh;
  logic        ge;

  assign sh = {rem_q, num_q[63]};
  assign ge = sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      num_q <= {num_q[62:0], ge};
      rem_q <= ge ? 32'(sh - {1'b0, den_q}) : sh[31:0];
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = num_q;

endmodule
`default_nettype wire

>>> rtl/rb2s_sqrt.sv
// ----------------------------------------------------------------------------
// rb2s_sqrt
// Integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rb2s_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] rad_i,
  output logic             busy_o,
  output logic [31:0]      root_o
);

  logic        busy_q;
  logic [63:0] x_q;
  logic [63:0] r_q;
  logic [63:0] bit_q;
  logic [63:0] trial;

  assign trial = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && bit_q[0]) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= rad_i;
      r_q   <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if (x_q >= trial) begin
        x_q <= x_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign busy_o = busy_q;
  assign root_o = r_q[31:0];

endmodule
`default_nettype wire

>>> rtl/rb2s_dp.sv
// ----------------------------------------------------------------------------
// rb2s_dp
// Datapath: configuration, velocity state, multipliers, divide and root units.
// ----------------------------------------------------------------------------
`default_nettype none
module rb2s_dp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [rb2s_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [rb2s_pkg::CfgW-1:0]    cfg_wdata_i,
  input  wire logic signed [31:0]           force_x_i,
  input  wire logic signed [31:0]           force_y_i,
  input  wire logic [15:0]                  delta_time_i,
  input  wire logic                         on_ground_i,
  input  wire logic signed [47:0]           pos_x_in_i,
  input  wire logic signed [47:0]           pos_y_in_i,
  input  wire rb2s_pkg::cmd_t               cmd_i,
  output rb2s_pkg::sts_t                    sts_o,
  output logic signed [47:0]                pos_x_out_o,
  output logic signed [47:0]                pos_y_out_o,
  output logic signed [31:0]                vel_x_out_o,
  output logic signed [31:0]                vel_y_out_o
);

  logic [15:0] mass_q;
  logic [30:0] fric_q;
  logic [15:0] fscl_q;
  logic [30:0] slim_q;
  logic [30:0] flim_q;
  logic [30:0] grav_q;
  logic        gen_q;

  logic signed [31:0] vx_q, vy_q;
  logic signed [31:0] fx_q, fy_q;
  logic signed [47:0] px_q, py_q;
  logic [15:0]        dt_q;
  logic               gnd_q;
  logic [63:0]        p_q, t_q;
  logic [47:0]        c_q;

  logic [15:0] m_eff;
  logic [31:0] ma, mb;
  logic [63:0] mprod;
  logic [47:0] wa;
  logic [15:0] wb;
  logic [63:0] wprod;
  logic        div_start, div_busy, sqrt_start, sqrt_busy;
  logic [31:0] div_den;
  logic [63:0] quo;
  logic [31:0] root;
  logic [31:0] magx, magy;

  assign m_eff = (mass_q == '0) ? 16'd1 : mass_q;
  assign magx  = rb2s_pkg::mag32(vx_q);
  assign magy  = rb2s_pkg::mag32(vy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q <= 16'd256;
      fric_q <= 31'd19660800;
      fscl_q <= 16'd256;
      slim_q <= 31'd655360000;
      flim_q <= 31'd655360000;
      grav_q <= 31'd6553600;
      gen_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rb2s_pkg::CFG_MASS:      mass_q <= cfg_wdata_i[15:0];
        rb2s_pkg::CFG_FRICTION:  fric_q <= cfg_wdata_i;
        rb2s_pkg::CFG_FRIC_SCL:  fscl_q <= cfg_wdata_i[15:0];
        rb2s_pkg::CFG_SPEED_LIM: slim_q <= cfg_wdata_i;
        rb2s_pkg::CFG_FALL_LIM:  flim_q <= cfg_wdata_i;
        rb2s_pkg::CFG_GRAVITY:   grav_q <= cfg_wdata_i;
        rb2s_pkg::CFG_GRAV_EN:   gen_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ma = '0;
    mb = '0;
    wa = '0;
    wb = '0;
    case (cmd_i.op)
      rb2s_pkg::OP_MUL_FX:  begin ma = rb2s_pkg::mag32(fx_q); mb = {16'd0, dt_q}; end
      rb2s_pkg::OP_MUL_FY:  begin ma = rb2s_pkg::mag32(fy_q); mb = {16'd0, dt_q}; end
      rb2s_pkg::OP_SQ_X:    begin ma = magx; mb = magx; end
      rb2s_pkg::OP_SQ_Y:    begin ma = magy; mb = magy; end
      rb2s_pkg::OP_MUL_VXC: begin ma = magx; mb = c_q[31:0]; end
      rb2s_pkg::OP_MUL_VYC: begin ma = magy; mb = c_q[31:0]; end
      rb2s_pkg::OP_MUL_G:   begin ma = {1'b0, grav_q}; mb = {16'd0, dt_q}; end
      rb2s_pkg::OP_MUL_VXL: begin ma = magx; mb = {1'b0, slim_q}; end
      rb2s_pkg::OP_MUL_VYL: begin ma = magy; mb = {1'b0, slim_q}; end
      rb2s_pkg::OP_MUL_PX:  begin ma = magx; mb = {16'd0, dt_q}; end
      rb2s_pkg::OP_MUL_PY:  begin ma = magy; mb = {16'd0, dt_q}; end
      rb2s_pkg::OP_MUL_C1:  begin wa = {17'd0, fric_q}; wb = fscl_q; end
      rb2s_pkg::OP_MUL_C2:  begin wa = c_q; wb = m_eff; end
      rb2s_pkg::OP_MUL_C3:  begin wa = c_q; wb = dt_q; end
      default: ;
    endcase
  end

  assign mprod = 64'(ma) * 64'(mb);
  assign wprod = 64'(wa) * 64'(wb);

  assign div_start  = cmd_i.op == rb2s_pkg::OP_DIV_ACC || cmd_i.op == rb2s_pkg::OP_DIV_LEN;
  assign div_den    = (cmd_i.op == rb2s_pkg::OP_DIV_ACC) ? {8'd0, m_eff, 8'd0} : root;
  assign sqrt_start = cmd_i.op == rb2s_pkg::OP_SQRT;

  rb2s_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (p_q),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  rb2s_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (t_q + p_q),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vx_q <= '0;
      vy_q <= '0;
    end else begin
      case (cmd_i.op)
        rb2s_pkg::OP_ADD_AX: vx_q <= rb2s_pkg::sat_vel(fx_q[31]
                               ? 66'(vx_q) - $signed({2'b00, quo})
                               : 66'(vx_q) + $signed({2'b00, quo}));
        rb2s_pkg::OP_ADD_AY: vy_q <= rb2s_pkg::sat_vel(fy_q[31]
                               ? 66'(vy_q) - $signed({2'b00, quo})
                               : 66'(vy_q) + $signed({2'b00, quo}));
        rb2s_pkg::OP_ZERO_V: begin
          vx_q <= '0;
          vy_q <= '0;
        end
        rb2s_pkg::OP_SUB_X: vx_q <= vx_q[31] ? vx_q + $signed(quo[31:0])
                                             : vx_q - $signed(quo[31:0]);
        rb2s_pkg::OP_SUB_Y: vy_q <= vy_q[31] ? vy_q + $signed(quo[31:0])
                                             : vy_q - $signed(quo[31:0]);
        rb2s_pkg::OP_ADD_G: vy_q <= rb2s_pkg::sat_vel(66'(vy_q)
                               + $signed({34'd0, p_q[47:16]}));
        rb2s_pkg::OP_CLAMP: begin
          if (magx > {1'b0, slim_q}) begin
            vx_q <= vx_q[31] ? $signed(32'(0 - {1'b0, slim_q})) : $signed({1'b0, slim_q});
          end
          if (magy > {1'b0, flim_q}) begin
            vy_q <= vy_q[31] ? $signed(32'(0 - {1'b0, flim_q})) : $signed({1'b0, flim_q});
          end
        end
        rb2s_pkg::OP_SET_X: vx_q <= vx_q[31] ? $signed(32'(0 - quo[31:0])) : $signed(quo[31:0]);
        rb2s_pkg::OP_SET_Y: vy_q <= vy_q[31] ? $signed(32'(0 - quo[31:0])) : $signed(quo[31:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      fx_q  <= force_x_i;
      fy_q  <= force_y_i;
      dt_q  <= delta_time_i;
      gnd_q <= on_ground_i;
      px_q  <= pos_x_in_i;
      py_q  <= pos_y_in_i;
    end
    case (cmd_i.op)
      rb2s_pkg::OP_MUL_FX, rb2s_pkg::OP_MUL_FY, rb2s_pkg::OP_SQ_Y,
      rb2s_pkg::OP_MUL_VXC, rb2s_pkg::OP_MUL_VYC, rb2s_pkg::OP_MUL_G,
      rb2s_pkg::OP_MUL_VXL, rb2s_pkg::OP_MUL_VYL, rb2s_pkg::OP_MUL_PX,
      rb2s_pkg::OP_MUL_PY: p_q <= mprod;
      rb2s_pkg::OP_SQ_X:   t_q <= mprod;
      rb2s_pkg::OP_MUL_C1: c_q <= wprod[55:8];
      rb2s_pkg::OP_MUL_C2: c_q <= wprod[55:8];
      rb2s_pkg::OP_MUL_C3: c_q <= wprod[63:16];
      rb2s_pkg::OP_ADD_PX: px_q <= rb2s_pkg::sat_pos(vx_q[31]
                             ? 50'(px_q) - $signed({18'd0, p_q[47:16]})
                             : 50'(px_q) + $signed({18'd0, p_q[47:16]}));
      rb2s_pkg::OP_ADD_PY: py_q <= rb2s_pkg::sat_pos(vy_q[31]
                             ? 50'(py_q) - $signed({18'd0, p_q[47:16]})
                             : 50'(py_q) + $signed({18'd0, p_q[47:16]}));
      rb2s_pkg::OP_LOAD: begin
        pos_x_out_o <= px_q;
        pos_y_out_o <= py_q;
        vel_x_out_o <= vx_q;
        vel_y_out_o <= vy_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts_o.div_busy   = div_busy;
    sts_o.sqrt_busy  = sqrt_busy;
    sts_o.len_le_c   = {16'd0, root} <= c_q;
    sts_o.len_gt_lim = root > {1'b0, slim_q};
    sts_o.grav       = gen_q;
    sts_o.ground     = gnd_q;
  end

endmodule
`default_nettype wire

>>> rtl/rb2s_ctrl.sv
// ----------------------------------------------------------------------------
// rb2s_ctrl
// Sequencer: steps the datapath through one frame update and runs the handshake.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rigid_body_2d_step_defines.svh"
module rb2s_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire rb2s_pkg::sts_t sts_i,
  output rb2s_pkg::cmd_t      cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE,
    S_AX_MUL, S_AX_DIV, S_AX_WAIT, S_AX_ADD,
    S_AY_MUL, S_AY_DIV, S_AY_WAIT, S_AY_ADD,
    S_C1, S_C2, S_C3,
    S_FSQX, S_FSQY, S_FSQRT, S_FSQW, S_FCHK,
    S_FX_MUL, S_FX_DIV, S_FX_WAIT, S_FX_SUB,
    S_FY_MUL, S_FY_DIV, S_FY_WAIT, S_FY_SUB,
    S_G_MUL, S_G_ADD,
    S_LIM,
    S_LSQX, S_LSQY, S_LSQRT, S_LSQW, S_LCHK,
    S_LX_MUL, S_LX_DIV, S_LX_WAIT, S_LX_SET,
    S_LY_MUL, S_LY_DIV, S_LY_WAIT, S_LY_SET,
    S_PX_MUL, S_PX_ADD, S_PY_MUL, S_PY_ADD,
    S_LOAD
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   div_go;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.op      = rb2s_pkg::OP_NONE;
    out_valid_d   = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = S_AX_MUL;
      end
      S_AX_MUL:  begin cmd_o.op = rb2s_pkg::OP_MUL_FX;  state_d = S_AX_DIV; end
      S_AX_DIV:  begin cmd_o.op = rb2s_pkg::OP_DIV_ACC; state_d = S_AX_WAIT; end
      S_AX_WAIT: if (!sts_i.div_busy) state_d = S_AX_ADD;
      S_AX_ADD:  begin cmd_o.op = rb2s_pkg::OP_ADD_AX;  state_d = S_AY_MUL; end
      S_AY_MUL:  begin cmd_o.op = rb2s_pkg::OP_MUL_FY;  state_d = S_AY_DIV; end
      S_AY_DIV:  begin cmd_o.op = rb2s_pkg::OP_DIV_ACC; state_d = S_AY_WAIT; end
      S_AY_WAIT: if (!sts_i.div_busy) state_d = S_AY_ADD;
      S_AY_ADD: begin
        cmd_o.op = rb2s_pkg::OP_ADD_AY;
        state_d  = (!sts_i.grav || sts_i.ground) ? S_C1 : S_G_MUL;
      end
      S_C1:    begin cmd_o.op = rb2s_pkg::OP_MUL_C1; state_d = S_C2; end
      S_C2:    begin cmd_o.op = rb2s_pkg::OP_MUL_C2; state_d = S_C3; end
      S_C3:    begin cmd_o.op = rb2s_pkg::OP_MUL_C3; state_d = S_FSQX; end
      S_FSQX:  begin cmd_o.op = rb2s_pkg::OP_SQ_X;   state_d = S_FSQY; end
      S_FSQY:  begin cmd_o.op = rb2s_pkg::OP_SQ_Y;   state_d = S_FSQRT; end
      S_FSQRT: begin cmd_o.op = rb2s_pkg::OP_SQRT;   state_d = S_FSQW; end
      S_FSQW:  if (!sts_i.sqrt_busy) state_d = S_FCHK;
      S_FCHK: begin
        if (sts_i.len_le_c) begin
          cmd_o.op = rb2s_pkg::OP_ZERO_V;
          state_d  = S_LIM;
        end else begin
          state_d = S_FX_MUL;
        end
      end
      S_FX_MUL:  begin cmd_o.op = rb2s_pkg::OP_MUL_VXC; state_d = S_FX_DIV; end
      S_FX_DIV:  begin cmd_o.op = rb2s_pkg::OP_DIV_LEN; state_d = S_FX_WAIT; end
      S_FX_WAIT: if (!sts_i.div_busy) state_d = S_FX_SUB;
      S_FX_SUB:  begin cmd_o.op = rb2s_pkg::OP_SUB_X;   state_d = S_FY_MUL; end
      S_FY_MUL:  begin cmd_o.op = rb2s_pkg::OP_MUL_VYC; state_d = S_FY_DIV; end
      S_FY_DIV:  begin cmd_o.op = rb2s_pkg::OP_DIV_LEN; state_d = S_FY_WAIT; end
      S_FY_WAIT: if (!sts_i.div_busy) state_d = S_FY_SUB;
      S_FY_SUB:  begin cmd_o.op = rb2s_pkg::OP_SUB_Y;   state_d = S_LIM; end
      S_G_MUL:   begin cmd_o.op = rb2s_pkg::OP_MUL_G;   state_d = S_G_ADD; end
      S_G_ADD:   begin cmd_o.op = rb2s_pkg::OP_ADD_G;   state_d = S_LIM; end
      S_LIM: begin
        if (sts_i.grav) begin
          cmd_o.op = rb2s_pkg::OP_CLAMP;
          state_d  = S_PX_MUL;
        end else begin
          state_d = S_LSQX;
        end
      end
      S_LSQX:  begin cmd_o.op = rb2s_pkg::OP_SQ_X; state_d = S_LSQY; end
      S_LSQY:  begin cmd_o.op = rb2s_pkg::OP_SQ_Y; state_d = S_LSQRT; end
      S_LSQRT: begin cmd_o.op = rb2s_pkg::OP_SQRT; state_d = S_LSQW; end
      S_LSQW:  if (!sts_i.sqrt_busy) state_d = S_LCHK;
      S_LCHK:  state_d = sts_i.len_gt_lim ? S_LX_MUL : S_PX_MUL;
      S_LX_MUL:  begin cmd_o.op = rb2s_pkg::OP_MUL_VXL; state_d = S_LX_DIV; end
      S_LX_DIV:  begin cmd_o.op = rb2s_pkg::OP_DIV_LEN; state_d = S_LX_WAIT; end
      S_LX_WAIT: if (!sts_i.div_busy) state_d = S_LX_SET;
      S_LX_SET:  begin cmd_o.op = rb2s_pkg::OP_SET_X;   state_d = S_LY_MUL; end
      S_LY_MUL:  begin cmd_o.op = rb2s_pkg::OP_MUL_VYL; state_d = S_LY_DIV; end
      S_LY_DIV:  begin cmd_o.op = rb2s_pkg::OP_DIV_LEN; state_d = S_LY_WAIT; end
      S_LY_WAIT: if (!sts_i.div_busy) state_d = S_LY_SET;
      S_LY_SET:  begin cmd_o.op = rb2s_pkg::OP_SET_Y;   state_d = S_PX_MUL; end
      S_PX_MUL:  begin cmd_o.op = rb2s_pkg::OP_MUL_PX;  state_d = S_PX_ADD; end
      S_PX_ADD:  begin cmd_o.op = rb2s_pkg::OP_ADD_PX;  state_d = S_PY_MUL; end
      S_PY_MUL:  begin cmd_o.op = rb2s_pkg::OP_MUL_PY;  state_d = S_PY_ADD; end
      S_PY_ADD:  begin cmd_o.op = rb2s_pkg::OP_ADD_PY;  state_d = S_LOAD; end
      S_LOAD: begin
        if (out_free) begin
          cmd_o.op    = rb2s_pkg::OP_LOAD;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign div_go      = cmd_o.op == rb2s_pkg::OP_DIV_ACC || cmd_o.op == rb2s_pkg::OP_DIV_LEN;

  `RB2S_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `RB2S_ASSERT_IMP(a_div_idle_on_start, clk_i, rst_ni, div_go, !sts_i.div_busy)
  `RB2S_ASSERT_IMP(a_sqrt_idle_on_start, clk_i, rst_ni, cmd_o.op == rb2s_pkg::OP_SQRT, !sts_i.sqrt_busy)
  `RB2S_ASSERT_IMP(a_load_only_when_free, clk_i, rst_ni, cmd_o.op == rb2s_pkg::OP_LOAD, out_free)

endmodule
`default_nettype wire

>>> rtl/rigid_body_2d_step.sv
// ----------------------------------------------------------------------------
// rigid_body_2d_step
// Semi-implicit Euler update of one 2D body: velocity kept, position advanced.
// ----------------------------------------------------------------------------
// Each frame update runs through the bit-serial divider (up to six divides)
//   and the root unit (up to two roots); a new item is taken only after the
//   previous one has been loaded to the outputs, and the next item is taken
//   while a result waits. Reset: velocity clears, registers take their defaults.
`default_nettype none
module rigid_body_2d_step (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [rb2s_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [rb2s_pkg::CfgW-1:0]    cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic signed [31:0]           force_x_i,
  input  wire logic signed [31:0]           force_y_i,
  input  wire logic [15:0]                  delta_time_i,
  input  wire logic                         on_ground_i,
  input  wire logic signed [47:0]           pos_x_in_i,
  input  wire logic signed [47:0]           pos_y_in_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed [47:0]                pos_x_out_o,
  output logic signed [47:0]                pos_y_out_o,
  output logic signed [31:0]                vel_x_out_o,
  output logic signed [31:0]                vel_y_out_o
);

  rb2s_pkg::cmd_t cmd;
  rb2s_pkg::sts_t sts;

  rb2s_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rb2s_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .force_x_i    (force_x_i),
    .force_y_i    (force_y_i),
    .delta_time_i (delta_time_i),
    .on_ground_i  (on_ground_i),
    .pos_x_in_i   (pos_x_in_i),
    .pos_y_in_i   (pos_y_in_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .pos_x_out_o  (pos_x_out_o),
    .pos_y_out_o  (pos_y_out_o),
    .vel_x_out_o  (vel_x_out_o),
    .vel_y_out_o  (vel_y_out_o)
  );

endmodule
`default_nettype wire

>>> sim/rigid_body_2d_step_chk.sv
// ----------------------------------------------------------------------------
// rigid_body_2d_step_chk
// Watches the configuration port and both channels of the rigid body step
// block, predicts each result from its own copy of the registers and velocity,
// and compares every output transfer field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rigid_body_2d_step_chk (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [rb2s_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [rb2s_pkg::CfgW-1:0]    cfg_wdata_i,
  input  wire logic                         in_valid_i,
  input  wire logic                         in_ready_i,
  input  wire logic signed [31:0]           force_x_i,
  input  wire logic signed [31:0]           force_y_i,
  input  wire logic [15:0]                  delta_time_i,
  input  wire logic                         on_ground_i,
  input  wire logic signed [47:0]           pos_x_in_i,
  input  wire logic signed [47:0]           pos_y_in_i,
  input  wire logic                         out_valid_i,
  input  wire logic                         out_ready_i,
  input  wire logic signed [47:0]           pos_x_out_i,
  input  wire logic signed [47:0]           pos_y_out_i,
  input  wire logic signed [31:0]           vel_x_out_i,
  input  wire logic signed [31:0]           vel_y_out_i,
  output int                                mismatches_o,
  output int                                pending_o
);

  localparam longint VelMax = 64'sd2147483647;
  localparam longint VelMin = -64'sd2147483648;
  localparam longint PosMax = 64'sd140737488355327;
  localparam longint PosMin = -64'sd140737488355328;

  typedef struct {
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } body_state_t;

  body_state_t body_q[$];

  longint unsigned mass_r, fric_r, fscale_r, spd_lim_r, fall_lim_r, grav_r;
  logic            grav_en_r;
  longint          vel_x_r, vel_y_r;

  function automatic longint clampl(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint unsigned magl(longint x);
    return x < 0 ? longint'(0) - x : x;
  endfunction

  function automatic longint signed_as(longint ref_v, longint unsigned m);
    return ref_v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned body_speed();
    longint unsigned ax, ay;
    ax = magl(vel_x_r);
    ay = magl(vel_y_r);
    return int_sqrt(ax * ax + ay * ay);
  endfunction

  function automatic body_state_t integrate(longint fx, longint fy, longint unsigned dt,
                                            logic gnd, longint px, longint py);
    body_state_t     r;
    longint unsigned m, den, c, len;
    logic            grav;
    m    = mass_r == 0 ? 1 : mass_r;
    den  = m * 256;
    grav = grav_en_r;
    vel_x_r = clampl(vel_x_r + signed_as(fx, magl(fx) * dt / den), VelMin, VelMax);
    vel_y_r = clampl(vel_y_r + signed_as(fy, magl(fy) * dt / den), VelMin, VelMax);
    if (!grav || gnd) begin
      c = (fric_r * fscale_r) >> 8;
      c = (c * m) >> 8;
      c = (c * dt) >> 16;
      len = body_speed();
      if (len <= c) begin
        vel_x_r = 0;
        vel_y_r = 0;
      end else begin
        vel_x_r = vel_x_r - signed_as(vel_x_r, magl(vel_x_r) * c / len);
        vel_y_r = vel_y_r - signed_as(vel_y_r, magl(vel_y_r) * c / len);
      end
    end
    if (grav && !gnd) begin
      vel_y_r = clampl(vel_y_r + longint'((grav_r * dt) >> 16), VelMin, VelMax);
    end
    if (grav) begin
      if (magl(vel_x_r) > spd_lim_r) vel_x_r = signed_as(vel_x_r, spd_lim_r);
      if (magl(vel_y_r) > fall_lim_r) vel_y_r = signed_as(vel_y_r, fall_lim_r);
    end else begin
      len = body_speed();
      if (len > spd_lim_r) begin
        vel_x_r = signed_as(vel_x_r, magl(vel_x_r) * spd_lim_r / len);
        vel_y_r = signed_as(vel_y_r, magl(vel_y_r) * spd_lim_r / len);
      end
    end
    px = clampl(px + signed_as(vel_x_r, (magl(vel_x_r) * dt) >> 16), PosMin, PosMax);
    py = clampl(py + signed_as(vel_y_r, (magl(vel_y_r) * dt) >> 16), PosMin, PosMax);
    r.pos_x = px[47:0];
    r.pos_y = py[47:0];
    r.vel_x = vel_x_r[31:0];
    r.vel_y = vel_y_r[31:0];
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      if (mismatches_o < 10) begin
        $display("[%0t] %s mismatch: expected %h, got %h", $realtime, name, exp_v, act_v);
      end
      mismatches_o++;
    end
  endtask

  assign pending_o = body_q.size();

  initial mismatches_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    body_state_t e;
    if (!rst_ni) begin
      mass_r     <= 256;
      fric_r     <= 19660800;
      fscale_r   <= 256;
      spd_lim_r  <= 655360000;
      fall_lim_r <= 655360000;
      grav_r     <= 6553600;
      grav_en_r  <= 1'b0;
      vel_x_r    = 0;
      vel_y_r    = 0;
      body_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rb2s_pkg::CFG_MASS:      mass_r     <= cfg_wdata_i[15:0];
          rb2s_pkg::CFG_FRICTION:  fric_r     <= cfg_wdata_i[30:0];
          rb2s_pkg::CFG_FRIC_SCL:  fscale_r   <= cfg_wdata_i[15:0];
          rb2s_pkg::CFG_SPEED_LIM: spd_lim_r  <= cfg_wdata_i[30:0];
          rb2s_pkg::CFG_FALL_LIM:  fall_lim_r <= cfg_wdata_i[30:0];
          rb2s_pkg::CFG_GRAVITY:   grav_r     <= cfg_wdata_i[30:0];
          rb2s_pkg::CFG_GRAV_EN:   grav_en_r  <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        body_q.push_back(integrate(force_x_i, force_y_i, delta_time_i, on_ground_i,
                                   pos_x_in_i, pos_y_in_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (body_q.size() == 0) begin
          if (mismatches_o < 10) $display("[%0t] unexpected result transfer", $realtime);
          mismatches_o++;
        end else begin
          e = body_q.pop_front();
          check_field("pos_x", e.pos_x, pos_x_out_i);
          check_field("pos_y", e.pos_y, pos_y_out_i);
          check_field("vel_x", e.vel_x, vel_x_out_i);
          check_field("vel_y", e.vel_y, vel_y_out_i);
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> sim/tb_rigid_body_2d_step.sv
// ----------------------------------------------------------------------------
// tb_rigid_body_2d_step
// Drives frame ticks into the rigid body step block over several register
// settings, with random gaps and stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_rigid_body_2d_step;

  localparam logic [rb2s_pkg::CfgIdxW-1:0] CFG_UNUSED = 3'd7;
  localparam int                           CycleLimit = 1500000;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [rb2s_pkg::CfgIdxW-1:0]  cfg_idx = '0;
  logic [rb2s_pkg::CfgW-1:0]     cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [31:0]            force_x = '0;
  logic signed [31:0]            force_y = '0;
  logic [15:0]                   delta_time = '0;
  logic                          on_ground = 1'b0;
  logic signed [47:0]            pos_x_in = '0;
  logic signed [47:0]            pos_y_in = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [47:0]            pos_x_out, pos_y_out;
  logic signed [31:0]            vel_x_out, vel_y_out;
  int                            mismatches, pending;
  int                            cycles = 0;
  logic                          idle_on = 1'b1;
  logic                          hold_req = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  rigid_body_2d_step DUT (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_wdata_i(cfg_wdata), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .force_x_i(force_x), .force_y_i(force_y), .delta_time_i(delta_time),
    .on_ground_i(on_ground), .pos_x_in_i(pos_x_in), .pos_y_in_i(pos_y_in),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .pos_x_out_o(pos_x_out),
    .pos_y_out_o(pos_y_out), .vel_x_out_o(vel_x_out), .vel_y_out_o(vel_y_out)
  );

  rigid_body_2d_step_chk u_chk (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_wdata_i(cfg_wdata), .in_valid_i(in_valid), .in_ready_i(in_ready),
    .force_x_i(force_x), .force_y_i(force_y), .delta_time_i(delta_time),
    .on_ground_i(on_ground), .pos_x_in_i(pos_x_in), .pos_y_in_i(pos_y_in),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .pos_x_out_i(pos_x_out),
    .pos_y_out_i(pos_y_out), .vel_x_out_i(vel_x_out), .vel_y_out_i(vel_y_out),
    .mismatches_o(mismatches), .pending_o(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_req <= 1'b0;
      end
      stall = idle_on ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic cfg_write(logic [rb2s_pkg::CfgIdxW-1:0] idx, logic [rb2s_pkg::CfgW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (600) @(posedge clk);
  endtask

  task automatic send_tick(logic signed [31:0] fx, logic signed [31:0] fy, logic [15:0] dt,
                           logic gnd, logic signed [47:0] px, logic signed [47:0] py);
    int gap;
    gap = idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    force_x    <= fx;
    force_y    <= fy;
    delta_time <= dt;
    on_ground  <= gnd;
    pos_x_in   <= px;
    pos_y_in   <= py;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [31:0] rand_force();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 4194304)) - 2097152);
      default: return 32'($signed($urandom_range(0, 67108864)) - 33554432);
    endcase
  endfunction

  function automatic logic [47:0] rand_pos();
    logic [47:0] p;
    p = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: p[46:20] = p[47] ? '0 : '1;
      1: p = 48'($signed(p[31:0]));
      default: ;
    endcase
    return p;
  endfunction

  task automatic random_ticks(int n);
    repeat (n) begin
      send_tick(rand_force(), rand_force(),
                ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4096)),
                1'($urandom_range(0, 1)), rand_pos(), rand_pos());
    end
  endtask

  task automatic write_all(logic [15:0] m, logic [30:0] f, logic [15:0] s, logic [30:0] sl,
                           logic [30:0] fl, logic [30:0] g, logic ge);
    cfg_write(rb2s_pkg::CFG_MASS, 31'({$urandom_range(0, 32767), m}));
    cfg_write(rb2s_pkg::CFG_FRICTION, f);
    cfg_write(rb2s_pkg::CFG_FRIC_SCL, 31'({$urandom_range(0, 32767), s}));
    cfg_write(rb2s_pkg::CFG_SPEED_LIM, sl);
    cfg_write(rb2s_pkg::CFG_FALL_LIM, fl);
    cfg_write(rb2s_pkg::CFG_GRAVITY, g);
    cfg_write(rb2s_pkg::CFG_GRAV_EN, 31'({$urandom, ge}));
    cfg_write(CFG_UNUSED, 31'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults: friction, zero velocity, extremes of every field
    send_tick(0, 0, 16'hFFFF, 1'b0, 0, 0);
    send_tick(32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF, 1'b0, 48'sh7FFF_FFFF_FFFF,
              48'sh8000_0000_0000);
    send_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF, 1'b1, 48'sh7FFF_FFFF_FF00,
              48'sh7FFF_FFFF_FF00);
    send_tick(32'sh8000_0000, 32'sh8000_0000, 16'hFFFF, 1'b1, 48'sh8000_0000_0100,
              48'sh8000_0000_0100);
    send_tick(32'sh0100_0000, -32'sh0100_0000, 0, 1'b0, -1, 1);
    send_tick(32'sh0001_0000, 32'sh0002_0000, 16'h0444, 1'b1, 0, 0);
    drain();

    // zero mass, no friction, widest limits
    write_all(0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
    send_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF, 1'b0, 48'sh7FFF_FFFF_FFFF, 0);
    send_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF, 1'b0, 48'sh7FFF_FFFF_FFFF, 0);
    send_tick(32'sh8000_0000, 32'sh8000_0000, 16'h0001, 1'b1, 0, 48'sh8000_0000_0000);
    drain();

    // gravity on: airborne and grounded, tight and wide per-axis limits
    write_all(16'hFFFF, 31'h7FFF_FFFF, 16'hFFFF, 31'h0010_0000, 31'h7FFF_FFFF,
              31'h7FFF_FFFF, 1'b1);
    send_tick(0, 0, 16'hFFFF, 1'b0, 0, 0);
    send_tick(0, 0, 16'hFFFF, 1'b0, 0, 0);
    send_tick(32'sh7FFF_FFFF, -32'sh7FFF_FFFF, 16'hFFFF, 1'b0, 0, 0);
    send_tick(32'sh7FFF_FFFF, 0, 16'hFFFF, 1'b1, 0, 0);
    send_tick(-32'sh7FFF_FFFF, 32'sh1000_0000, 16'h8000, 1'b0, 0, 0);
    drain();

    // gravity off with zero speed limit
    write_all(16'h0100, 31'h0001_0000, 16'h0001, 0, 0, 0, 1'b0);
    send_tick(32'sh1000_0000, 32'sh1000_0000, 16'h1000, 1'b0, 0, 0);
    drain();

    // random phases, each with fresh registers
    for (int ph = 0; ph < 6; ph++) begin
      idle_on = (ph != 2);
      if (ph[0]) begin
        write_all(16'($urandom_range(1, 1024)), 31'($urandom_range(0, 1 << 24)),
                  16'($urandom_range(0, 512)), 31'($urandom_range(1 << 16, 1 << 28)),
                  31'($urandom_range(1 << 16, 1 << 28)), 31'($urandom_range(0, 1 << 24)),
                  1'b1);
      end else begin
        write_all(16'($urandom), 31'($urandom), 16'($urandom), 31'($urandom),
                  31'($urandom), 31'($urandom), ph == 4);
      end
      if (ph == 3) hold_req <= 1'b1;
      random_ticks(100);
      drain();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
